FILE: rtl/json_object_stream_parser_core_assert.svh
// assertion macros used by the parser core rtl file
`ifndef JSON_OBJECT_STREAM_PARSER_CORE_ASSERT_SVH
`define JSON_OBJECT_STREAM_PARSER_CORE_ASSERT_SVH

// always-true property, checked out of reset
`define JSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("jsp assertion failed");

// antecedent implies consequent in the next cycle
`define JSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jsp assertion failed");

`endif

FILE: rtl/jsp_pkg.sv
`default_nettype none
package jsp_pkg;

  localparam logic [3:0] PH_VALUE       = 4'd0;
  localparam logic [3:0] PH_TOP_DONE    = 4'd1;
  localparam logic [3:0] PH_OBJ_FIRST   = 4'd2;
  localparam logic [3:0] PH_OBJ_NEXT    = 4'd3;
  localparam logic [3:0] PH_AFTER_KEY   = 4'd4;
  localparam logic [3:0] PH_AFTER_VALUE = 4'd5;
  localparam logic [3:0] PH_STRING      = 4'd6;
  localparam logic [3:0] PH_ESCAPE      = 4'd7;
  localparam logic [3:0] PH_HEX         = 4'd8;
  localparam logic [3:0] PH_NUM_SIGN    = 4'd9;
  localparam logic [3:0] PH_NUM_ZERO    = 4'd10;
  localparam logic [3:0] PH_NUM_DIGITS  = 4'd11;
  localparam logic [3:0] PH_LITERAL     = 4'd12;
  localparam logic [3:0] PH_FAILED      = 4'd13;

  localparam logic [3:0] EV_OPEN    = 4'd0;
  localparam logic [3:0] EV_CLOSE   = 4'd1;
  localparam logic [3:0] EV_KEYCHAR = 4'd2;
  localparam logic [3:0] EV_KEYEND  = 4'd3;
  localparam logic [3:0] EV_STRCHAR = 4'd4;
  localparam logic [3:0] EV_STREND  = 4'd5;
  localparam logic [3:0] EV_INT     = 4'd6;
  localparam logic [3:0] EV_TRUE    = 4'd7;
  localparam logic [3:0] EV_OK      = 4'd10;
  localparam logic [3:0] EV_ERROR   = 4'd11;

  localparam logic [4:0] ERR_DEPTH       = 5'd1;
  localparam logic [4:0] ERR_END         = 5'd2;
  localparam logic [4:0] ERR_VALUE       = 5'd3;
  localparam logic [4:0] ERR_COLON       = 5'd4;
  localparam logic [4:0] ERR_COMMA       = 5'd5;
  localparam logic [4:0] ERR_UNTERM_OBJ  = 5'd6;
  localparam logic [4:0] ERR_KEY         = 5'd7;
  localparam logic [4:0] ERR_CTRL        = 5'd8;
  localparam logic [4:0] ERR_UNTERM_ESC  = 5'd9;
  localparam logic [4:0] ERR_SHORT_HEX   = 5'd10;
  localparam logic [4:0] ERR_HEX_DIGIT   = 5'd11;
  localparam logic [4:0] ERR_NON_ASCII   = 5'd12;
  localparam logic [4:0] ERR_ESC_LETTER  = 5'd13;
  localparam logic [4:0] ERR_UNTERM_STR  = 5'd14;
  localparam logic [4:0] ERR_DIGIT       = 5'd15;
  localparam logic [4:0] ERR_LEAD_ZERO   = 5'd16;
  localparam logic [4:0] ERR_OVERFLOW    = 5'd17;
  localparam logic [4:0] ERR_TRAILING    = 5'd18;

  localparam logic [3:0] MAX_DEPTH_RESET = 4'd8;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  open_cnt;
    logic [63:0] acc;
    logic        neg;
    logic [15:0] esc;
    logic [2:0]  hex_cnt;
    logic        hex_bad;
    logic [2:0]  lit_idx;
    logic [1:0]  lit_kind;
    logic        is_key;
    logic [4:0]  err;
  } st_t;

  localparam st_t ST_RESET = '{phase: PH_VALUE, default: '0};

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  ch;
    logic [63:0] iv;
    logic [4:0]  err;
    logic        last;
  } ev_t;

  typedef struct packed {
    ev_t [2:0]  ev;
    logic [1:0] cnt;
  } evs_t;

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    lit_len = (kind == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (kind)
      2'd0: case (idx)
        3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00;
      endcase
      2'd1: case (idx)
        3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
        default: c = 8'h00;
      endcase
      2'd2: case (idx)
        3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l"; default: c = 8'h00;
      endcase
      default: c = 8'h00;
    endcase
    lit_char = c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/jsp_step.sv
`default_nettype none
module jsp_step (
  input  jsp_pkg::st_t  st_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic [3:0]    max_depth_i,
  output jsp_pkg::st_t  st_o,
  output jsp_pkg::evs_t evs_o
);
  import jsp_pkg::*;

  function automatic ev_t mk(input logic [3:0] k, input logic [7:0] c,
                             input logic [63:0] v, input logic [4:0] e);
    ev_t r;
    r.kind = k; r.ch = c; r.iv = v; r.err = e; r.last = 1'b0;
    mk = r;
  endfunction

  logic        ws, dig, failed_before, redo, hex_ok;
  logic [3:0]  hex_v;
  logic [67:0] prod;
  logic [63:0] limit, ival;
  logic [3:0]  ck;
  st_t         s;
  ev_t [2:0]   ev;
  logic [1:0]  n;
  logic [7:0]  b;

  assign b   = byte_i;
  assign ws  = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  assign dig = (b >= "0") && (b <= "9");

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = b[3:0];
    if (dig) hex_v = b[3:0];
    else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) hex_v = b[3:0] + 4'd9;
    else hex_ok = 1'b0;
  end

  // acc*10 + digit, overflow when above the signed limit
  assign limit = st_i.neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign prod  = {1'b0, st_i.acc, 3'b000} + {3'b000, st_i.acc, 1'b0} + {64'd0, b[3:0]};
  assign ival  = st_i.neg ? (64'd0 - st_i.acc) : st_i.acc;
  assign ck    = st_i.is_key ? EV_KEYCHAR : EV_STRCHAR;

  always_comb begin
    s  = st_i;
    ev = '0;
    n  = 2'd0;
    redo = 1'b0;
    failed_before = (st_i.phase == PH_FAILED);
    if (!failed_before) begin
      case (st_i.phase)
        PH_VALUE: begin
          if (ws) begin
          end else if (b == "{") begin
            s.open_cnt = s.open_cnt + 4'd1;
            ev[n] = mk(EV_OPEN, 8'd0, 64'd0, 5'd0); n = n + 2'd1;
            s.phase = PH_OBJ_FIRST;
          end else if (b == "\"") begin
            s.is_key = 1'b0; s.phase = PH_STRING;
          end else if (b == "-") begin
            s.neg = 1'b1; s.acc = 64'd0; s.phase = PH_NUM_SIGN;
          end else if (dig) begin
            s.neg = 1'b0; s.acc = {60'd0, b[3:0]};
            s.phase = (b == "0") ? PH_NUM_ZERO : PH_NUM_DIGITS;
          end else if (b == "t" || b == "f" || b == "n") begin
            s.lit_kind = (b == "t") ? 2'd0 : ((b == "f") ? 2'd1 : 2'd2);
            s.lit_idx = 3'd1; s.phase = PH_LITERAL;
          end else begin
            s.err = ERR_VALUE; s.phase = PH_FAILED;
            ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_VALUE); n = n + 2'd1;
          end
        end
        PH_TOP_DONE: if (!ws) begin
          s.err = ERR_TRAILING; s.phase = PH_FAILED;
          ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_TRAILING); n = n + 2'd1;
        end
        PH_OBJ_FIRST, PH_OBJ_NEXT: if (!ws) begin
          if (b == "}" && st_i.phase == PH_OBJ_FIRST) begin
            if (s.open_cnt != 4'd0) s.open_cnt = s.open_cnt - 4'd1;
            ev[n] = mk(EV_CLOSE, 8'd0, 64'd0, 5'd0); n = n + 2'd1;
            s.phase = (s.open_cnt != 4'd0) ? PH_AFTER_VALUE : PH_TOP_DONE;
          end else if (b == "\"") begin
            s.is_key = 1'b1; s.phase = PH_STRING;
          end else begin
            s.err = ERR_KEY; s.phase = PH_FAILED;
            ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_KEY); n = n + 2'd1;
          end
        end
        PH_AFTER_KEY: if (!ws) begin
          if (b != ":") begin
            s.err = ERR_COLON; s.phase = PH_FAILED;
            ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_COLON); n = n + 2'd1;
          end else if ({s.open_cnt, 1'b0} > {1'b0, max_depth_i}) begin
            s.err = ERR_DEPTH; s.phase = PH_FAILED;
            ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_DEPTH); n = n + 2'd1;
          end else begin
            s.phase = PH_VALUE;
          end
        end
        PH_AFTER_VALUE: redo = 1'b1;
        PH_STRING: begin
          if (b == "\"") begin
            if (s.is_key) begin
              ev[n] = mk(EV_KEYEND, 8'd0, 64'd0, 5'd0); n = n + 2'd1;
              s.phase = PH_AFTER_KEY;
            end else begin
              ev[n] = mk(EV_STREND, 8'd0, 64'd0, 5'd0); n = n + 2'd1;
              s.phase = (s.open_cnt != 4'd0) ? PH_AFTER_VALUE : PH_TOP_DONE;
            end
          end else if (b < 8'h20) begin
            s.err = ERR_CTRL; s.phase = PH_FAILED;
            ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_CTRL); n = n + 2'd1;
          end else if (b == "\\") begin
            s.phase = PH_ESCAPE;
          end else begin
            ev[n] = mk(ck, b, 64'd0, 5'd0); n = n + 2'd1;
          end
        end
        PH_ESCAPE: begin
          s.phase = PH_STRING;
          case (b)
            "\"", "\\", "/": begin ev[n] = mk(ck, b, 64'd0, 5'd0); n = n + 2'd1; end
            "b": begin ev[n] = mk(ck, 8'd8, 64'd0, 5'd0); n = n + 2'd1; end
            "f": begin ev[n] = mk(ck, 8'd12, 64'd0, 5'd0); n = n + 2'd1; end
            "n": begin ev[n] = mk(ck, 8'd10, 64'd0, 5'd0); n = n + 2'd1; end
            "r": begin ev[n] = mk(ck, 8'd13, 64'd0, 5'd0); n = n + 2'd1; end
            "t": begin ev[n] = mk(ck, 8'd9, 64'd0, 5'd0); n = n + 2'd1; end
            "u": begin
              s.esc = 16'd0; s.hex_cnt = 3'd0; s.hex_bad = 1'b0; s.phase = PH_HEX;
            end
            default: begin
              s.err = ERR_ESC_LETTER; s.phase = PH_FAILED;
              ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_ESC_LETTER); n = n + 2'd1;
            end
          endcase
        end
        PH_HEX: begin
          if (!hex_ok) s.hex_bad = 1'b1;
          else s.esc = {s.esc[11:0], hex_v};
          s.hex_cnt = s.hex_cnt + 3'd1;
          if (s.hex_cnt >= 3'd4) begin
            if (s.hex_bad) begin
              s.err = ERR_HEX_DIGIT; s.phase = PH_FAILED;
              ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_HEX_DIGIT); n = n + 2'd1;
            end else if (s.esc > 16'h007F) begin
              s.err = ERR_NON_ASCII; s.phase = PH_FAILED;
              ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_NON_ASCII); n = n + 2'd1;
            end else begin
              ev[n] = mk(ck, s.esc[7:0], 64'd0, 5'd0); n = n + 2'd1;
              s.phase = PH_STRING;
            end
          end
        end
        PH_NUM_SIGN: begin
          if (!dig) begin
            s.err = ERR_DIGIT; s.phase = PH_FAILED;
            ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_DIGIT); n = n + 2'd1;
          end else begin
            s.acc = {60'd0, b[3:0]};
            s.phase = (b == "0") ? PH_NUM_ZERO : PH_NUM_DIGITS;
          end
        end
        PH_NUM_ZERO, PH_NUM_DIGITS: begin
          if (dig && st_i.phase == PH_NUM_ZERO) begin
            s.err = ERR_LEAD_ZERO; s.phase = PH_FAILED;
            ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_LEAD_ZERO); n = n + 2'd1;
          end else if (dig) begin
            if (prod > {4'd0, limit}) begin
              s.err = ERR_OVERFLOW; s.phase = PH_FAILED;
              ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_OVERFLOW); n = n + 2'd1;
            end else begin
              s.acc = prod[63:0];
            end
          end else begin
            // number ends: int event, then this byte is seen again after a value
            ev[n] = mk(EV_INT, 8'd0, ival, 5'd0); n = n + 2'd1;
            s.phase = (s.open_cnt != 4'd0) ? PH_AFTER_VALUE : PH_TOP_DONE;
            redo = 1'b1;
          end
        end
        PH_LITERAL: begin
          if (s.lit_kind > 2'd2 || s.lit_idx >= lit_len(s.lit_kind) ||
              b != lit_char(s.lit_kind, s.lit_idx)) begin
            s.err = ERR_VALUE; s.phase = PH_FAILED;
            ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_VALUE); n = n + 2'd1;
          end else begin
            s.lit_idx = s.lit_idx + 3'd1;
            if (s.lit_idx == lit_len(s.lit_kind)) begin
              ev[n] = mk(EV_TRUE + {2'b00, s.lit_kind}, 8'd0, 64'd0, 5'd0); n = n + 2'd1;
              s.phase = (s.open_cnt != 4'd0) ? PH_AFTER_VALUE : PH_TOP_DONE;
            end
          end
        end
        default: begin
        end
      endcase

      // second look at the byte: only after-value phases reach here
      if (redo && !ws) begin
        if (s.phase == PH_TOP_DONE) begin
          s.err = ERR_TRAILING; s.phase = PH_FAILED;
          ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_TRAILING); n = n + 2'd1;
        end else if (b == "}") begin
          if (s.open_cnt != 4'd0) s.open_cnt = s.open_cnt - 4'd1;
          ev[n] = mk(EV_CLOSE, 8'd0, 64'd0, 5'd0); n = n + 2'd1;
          s.phase = (s.open_cnt != 4'd0) ? PH_AFTER_VALUE : PH_TOP_DONE;
        end else if (b == ",") begin
          s.phase = PH_OBJ_NEXT;
        end else begin
          s.err = ERR_COMMA; s.phase = PH_FAILED;
          ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_COMMA); n = n + 2'd1;
        end
      end
    end

    if (last_i) begin
      case (s.phase)
        PH_FAILED: if (failed_before) begin
          ev[n] = mk(EV_ERROR, 8'd0, 64'd0, s.err); n = n + 2'd1;
        end
        PH_VALUE: begin ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_END); n = n + 2'd1; end
        PH_TOP_DONE: begin ev[n] = mk(EV_OK, 8'd0, 64'd0, 5'd0); n = n + 2'd1; end
        PH_OBJ_FIRST, PH_OBJ_NEXT: begin
          ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_UNTERM_OBJ); n = n + 2'd1;
        end
        PH_AFTER_KEY: begin ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_COLON); n = n + 2'd1; end
        PH_AFTER_VALUE: begin ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_COMMA); n = n + 2'd1; end
        PH_STRING: begin
          ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_UNTERM_STR); n = n + 2'd1;
        end
        PH_ESCAPE: begin
          ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_UNTERM_ESC); n = n + 2'd1;
        end
        PH_HEX: begin ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_SHORT_HEX); n = n + 2'd1; end
        PH_NUM_SIGN: begin ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_DIGIT); n = n + 2'd1; end
        PH_NUM_ZERO, PH_NUM_DIGITS: begin
          // value includes a digit taken by this byte
          ev[n] = mk(EV_INT, 8'd0, s.neg ? (64'd0 - s.acc) : s.acc, 5'd0);
          n = n + 2'd1;
          if (s.open_cnt == 4'd0) ev[n] = mk(EV_OK, 8'd0, 64'd0, 5'd0);
          else ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_COMMA);
          n = n + 2'd1;
        end
        default: begin ev[n] = mk(EV_ERROR, 8'd0, 64'd0, ERR_VALUE); n = n + 2'd1; end
      endcase
      if (n != 2'd0) ev[n - 2'd1].last = 1'b1;
      s = ST_RESET;
    end
  end

  assign st_o      = s;
  assign evs_o.ev  = ev;
  assign evs_o.cnt = n;

endmodule
`default_nettype wire

FILE: rtl/jsp_evq.sv
`default_nettype none
module jsp_evq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsp_pkg::evs_t evs_i,
  input  logic          pop_i,
  output logic          room_o,
  output logic          valid_o,
  output jsp_pkg::ev_t  head_o,
  output logic [2:0]    count_o
);
  import jsp_pkg::*;

  ev_t        mem_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] n;

  assign n      = push_i ? evs_i.cnt : 2'd0;
  assign cnt_d  = cnt_q - {2'b00, pop_i} + {1'b0, n};
  // at least three free slots after this cycle's pop
  assign room_o = (cnt_q <= 3'd1) || ((cnt_q == 3'd2) && pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < evs_i.cnt) mem_q[wr_q + 2'(i)] <= evs_i.ev[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 2'd0;
      wr_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      rd_q  <= rd_q + {1'b0, pop_i};
      wr_q  <= wr_q + n;
      cnt_q <= cnt_d;
    end
  end

  assign valid_o = (cnt_q != 3'd0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule
`default_nettype wire

FILE: rtl/json_object_stream_parser_core.sv
`default_nettype none
// channel   dir  handshake               payload
// in        in   in_valid_i/in_ready_o   byte_value_i, end_of_text_i
// out       out  out_valid_o/out_ready_i event_kind_o, char_value_o, int_value_o,
//                                        error_code_o, last_result_o
// cfg       in   cfg_we_i                cfg_wdata_i (max_depth)
//
// one byte per cycle: the parse step is one combinational pass from the
// state register into a four-entry event queue
// bytes are taken back to back while the queue holds at most one event, or two
// with a pop in that cycle; with more than one event per byte the one-event
// output port sets the rate
// in_ready_o is high while the queue has at least three free slots after this cycle's pop
// reset puts the parser in the top-value phase with max_depth at 8
module json_object_stream_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_value_i,
  input  logic               end_of_text_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         event_kind_o,
  output logic [7:0]         char_value_o,
  output logic signed [63:0] int_value_o,
  output logic [4:0]         error_code_o,
  output logic               last_result_o
);
  import jsp_pkg::*;

  st_t        st_q, st_d;
  logic [3:0] max_depth_q;
  evs_t       evs;
  ev_t        head;
  logic       accept, pop;
  logic [2:0] q_cnt;

  // nesting bound register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_depth_q <= MAX_DEPTH_RESET;
    else if (cfg_we_i) max_depth_q <= cfg_wdata_i;
  end

  // one parse step per accepted item, up to three events
  jsp_step u_step (
    .st_i       (st_q),
    .byte_i     (byte_value_i),
    .last_i     (end_of_text_i),
    .max_depth_i(max_depth_q),
    .st_o       (st_d),
    .evs_o      (evs)
  );

  assign accept = in_valid_i && in_ready_o;
  assign pop    = out_valid_o && out_ready_i;

  // parser state only moves on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_RESET;
    else if (accept) st_q <= st_d;
  end

  // event queue decouples bursts of events from the input side
  jsp_evq u_evq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .evs_i  (evs),
    .pop_i  (pop),
    .room_o (in_ready_o),
    .valid_o(out_valid_o),
    .head_o (head),
    .count_o(q_cnt)
  );

  assign event_kind_o  = head.kind;
  assign char_value_o  = head.ch;
  assign int_value_o   = head.iv;
  assign error_code_o  = head.err;
  assign last_result_o = head.last;

  `include "json_object_stream_parser_core_assert.svh"

  // queue never overfills
  `JSP_ASSERT(a_q_bound, q_cnt <= 3'd4)
  // open-object count stays within what the depth check allows
  `JSP_ASSERT(a_depth_bound, st_q.open_cnt <= 4'd8)
  // the last byte of a document always returns the parser to reset
  `JSP_ASSERT_NEXT(a_doc_end, accept && end_of_text_i, st_q.phase == PH_VALUE)
  // events pushed into an empty queue show up on the output next cycle
  `JSP_ASSERT_NEXT(a_push_vis, accept && (evs.cnt != 2'd0) && (q_cnt == 3'd0), out_valid_o)

endmodule
`default_nettype wire
